### src/tekd_pkg.sv
// ----------------------------------------------------------------------------
// tekd_pkg: shared types and constants for the terminal escape key decoder
// Holds the parser state encoding, the command codes, the byte values the
// parser looks for, and the decode result struct passed between modules.
// ----------------------------------------------------------------------------
package tekd_pkg;

  localparam int unsigned KeyWidth = 8;
  localparam int unsigned CmdWidth = 4;

  // Parser position, one-hot.
  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_ESC   = 12'b0000_0000_0010,
    ST_CSI   = 12'b0000_0000_0100,
    ST_SS3   = 12'b0000_0000_1000,
    ST_CSI5  = 12'b0000_0001_0000,
    ST_CSI6  = 12'b0000_0010_0000,
    ST_CSI1  = 12'b0000_0100_0000,
    ST_CSI15 = 12'b0000_1000_0000,
    ST_CSI19 = 12'b0001_0000_0000,
    ST_CSI2  = 12'b0010_0000_0000,
    ST_CSI21 = 12'b0100_0000_0000,
    ST_SKIP  = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [CmdWidth-1:0] {
    CMD_UP     = 4'd0,
    CMD_DOWN   = 4'd1,
    CMD_PGUP   = 4'd2,
    CMD_PGDN   = 4'd3,
    CMD_HOME   = 4'd4,
    CMD_END    = 4'd5,
    CMD_COPY   = 4'd6,
    CMD_DELETE = 4'd7,
    CMD_SELECT = 4'd8,
    CMD_HELP   = 4'd9,
    CMD_VIEW   = 4'd10,
    CMD_DUMP   = 4'd11,
    CMD_EXIT   = 4'd12,
    CMD_PLAIN  = 4'd13
  } cmd_t;

  localparam logic [KeyWidth-1:0] CH_ESC    = 8'h1B;
  localparam logic [KeyWidth-1:0] CH_LBRACK = 8'h5B;
  localparam logic [KeyWidth-1:0] CH_O      = 8'h4F;
  localparam logic [KeyWidth-1:0] CH_TILDE  = 8'h7E;
  localparam logic [KeyWidth-1:0] CH_A      = 8'h41;
  localparam logic [KeyWidth-1:0] CH_B      = 8'h42;
  localparam logic [KeyWidth-1:0] CH_F      = 8'h46;
  localparam logic [KeyWidth-1:0] CH_H      = 8'h48;
  localparam logic [KeyWidth-1:0] CH_P      = 8'h50;
  localparam logic [KeyWidth-1:0] CH_R      = 8'h52;
  localparam logic [KeyWidth-1:0] CH_S      = 8'h53;
  localparam logic [KeyWidth-1:0] CH_T      = 8'h54;
  localparam logic [KeyWidth-1:0] CH_W      = 8'h57;
  localparam logic [KeyWidth-1:0] CH_Y      = 8'h59;
  localparam logic [KeyWidth-1:0] CH_0      = 8'h30;
  localparam logic [KeyWidth-1:0] CH_1      = 8'h31;
  localparam logic [KeyWidth-1:0] CH_2      = 8'h32;
  localparam logic [KeyWidth-1:0] CH_5      = 8'h35;
  localparam logic [KeyWidth-1:0] CH_6      = 8'h36;
  localparam logic [KeyWidth-1:0] CH_7      = 8'h37;
  localparam logic [KeyWidth-1:0] CH_8      = 8'h38;
  localparam logic [KeyWidth-1:0] CH_9      = 8'h39;

  // What one byte does to the parser.
  typedef struct packed {
    logic                has_result;
    cmd_t                command;
    logic [KeyWidth-1:0] plain_key;
    state_t              next_state;
  } dec_t;

endpackage

### src/tekd_in_reg.sv
// ----------------------------------------------------------------------------
// tekd_in_reg: input register
// Captures one key byte per beat and holds it until the decode stage
// consumes it; stalls the sender only while it is full and cannot drain.
// ----------------------------------------------------------------------------
module tekd_in_reg
  import tekd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KeyWidth-1:0] key_byte,
  input  logic                take,
  output logic                held_valid,
  output logic [KeyWidth-1:0] held_key
);

  logic load;

  assign in_stall = held_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= load || in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_key <= key_byte;
    end
  end

endmodule

### src/tekd_decode.sv
// ----------------------------------------------------------------------------
// tekd_decode: escape sequence decode logic
// Given the parser position and one byte, gives the next position and the
// command, if any, that the byte completes.
// ----------------------------------------------------------------------------
module tekd_decode
  import tekd_pkg::*;
(
  input  state_t              state,
  input  logic [KeyWidth-1:0] key,
  output dec_t                dec
);

  always_comb begin
    dec.has_result = 1'b0;
    dec.command    = CMD_UP;
    dec.plain_key  = '0;
    dec.next_state = ST_IDLE;

    unique case (state)
      ST_IDLE: begin
        if (key == CH_ESC) begin
          dec.next_state = ST_ESC;
        end else begin
          dec.has_result = 1'b1;
          dec.command    = CMD_PLAIN;
          dec.plain_key  = key;
        end
      end
      ST_ESC: begin
        unique case (key) inside
          CH_LBRACK: dec.next_state = ST_CSI;
          CH_O:      dec.next_state = ST_SS3;
          CH_A:      begin dec.has_result = 1'b1; dec.command = CMD_UP;   end
          CH_B:      begin dec.has_result = 1'b1; dec.command = CMD_DOWN; end
          CH_P:      begin dec.has_result = 1'b1; dec.command = CMD_HELP; end
          CH_R:      begin dec.has_result = 1'b1; dec.command = CMD_VIEW; end
          CH_S:      begin dec.has_result = 1'b1; dec.command = CMD_DUMP; end
          default:   dec.next_state = ST_IDLE;
        endcase
      end
      ST_CSI: begin
        unique case (key) inside
          CH_A:    begin dec.has_result = 1'b1; dec.command = CMD_UP;   end
          CH_B:    begin dec.has_result = 1'b1; dec.command = CMD_DOWN; end
          CH_H:    begin dec.has_result = 1'b1; dec.command = CMD_HOME; end
          CH_F:    begin dec.has_result = 1'b1; dec.command = CMD_END;  end
          CH_5:    dec.next_state = ST_CSI5;
          CH_6:    dec.next_state = ST_CSI6;
          CH_1:    dec.next_state = ST_CSI1;
          CH_2:    dec.next_state = ST_CSI2;
          default: dec.next_state = ST_IDLE;
        endcase
      end
      ST_SS3: begin
        unique case (key) inside
          CH_P:    begin dec.has_result = 1'b1; dec.command = CMD_HELP;   end
          CH_R:    begin dec.has_result = 1'b1; dec.command = CMD_VIEW;   end
          CH_S:    begin dec.has_result = 1'b1; dec.command = CMD_DUMP;   end
          CH_T:    begin dec.has_result = 1'b1; dec.command = CMD_COPY;   end
          CH_W:    begin dec.has_result = 1'b1; dec.command = CMD_DELETE; end
          CH_Y:    begin dec.has_result = 1'b1; dec.command = CMD_EXIT;   end
          default: dec.next_state = ST_IDLE;
        endcase
      end
      ST_CSI5: begin
        if (key == CH_TILDE) begin
          dec.has_result = 1'b1;
          dec.command    = CMD_PGUP;
        end
      end
      ST_CSI6: begin
        if (key == CH_TILDE) begin
          dec.has_result = 1'b1;
          dec.command    = CMD_PGDN;
        end
      end
      ST_CSI1: begin
        unique case (key) inside
          CH_5, CH_6: dec.next_state = ST_CSI15;
          CH_9:       dec.next_state = ST_CSI19;
          CH_7, CH_8: dec.next_state = ST_SKIP;
          default:    dec.next_state = ST_IDLE;
        endcase
      end
      ST_CSI15: begin
        if (key == CH_TILDE) begin
          dec.has_result = 1'b1;
          dec.command    = CMD_COPY;
        end
      end
      ST_CSI19: begin
        if (key == CH_TILDE) begin
          dec.has_result = 1'b1;
          dec.command    = CMD_DELETE;
        end
      end
      ST_CSI2: begin
        unique case (key) inside
          CH_TILDE:               begin dec.has_result = 1'b1; dec.command = CMD_SELECT; end
          CH_1:                   dec.next_state = ST_CSI21;
          CH_0, [CH_2:CH_9]:      dec.next_state = ST_SKIP;
          default:                dec.next_state = ST_IDLE;
        endcase
      end
      ST_CSI21: begin
        if (key == CH_TILDE) begin
          dec.has_result = 1'b1;
          dec.command    = CMD_EXIT;
        end else begin
          dec.next_state = ST_SKIP;
        end
      end
      default: begin
        // The skip position swallows one byte and falls back to idle.
        dec.next_state = ST_IDLE;
      end
    endcase
  end

endmodule

### src/terminal_escape_key_decoder_unit.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_unit: terminal escape key decoder, top level
// Each key byte is captured in the input register and decoded, and its result,
// if any, is then loaded into the result register, which presents it.
// Throughput: one key byte per cycle, with or without a result.
// The path from input register to result register is one decode step, so a
// new byte follows in the next cycle whenever the output side is not stalled.
// Reset (rst, synchronous, active high) returns the parser to idle and
// empties the input and result registers.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder_unit
  import tekd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KeyWidth-1:0] key_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CmdWidth-1:0] command,
  output logic [KeyWidth-1:0] plain_key
);

  // Held byte from the input register.
  logic                held_valid;
  logic [KeyWidth-1:0] held_key;

  // Parser position; it moves once per consumed byte.
  state_t parse_position;

  dec_t dec;
  logic advance;

  tekd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key_byte   (key_byte),
    .take       (advance),
    .held_valid (held_valid),
    .held_key   (held_key)
  );

  tekd_decode u_decode (
    .state (parse_position),
    .key   (held_key),
    .dec   (dec)
  );

  // The held byte is consumed when the result register can take its result,
  // either because it is empty or its beat completes now. A byte that gives
  // no result never waits on the output side.
  assign advance = held_valid && (!dec.has_result || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_position <= ST_IDLE;
    end else if (advance) begin
      parse_position <= dec.next_state;
    end
  end

  // Result register. It keeps its beat while stalled and clears once the
  // beat completes with nothing new behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && dec.has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec.has_result) begin
      command   <= dec.command;
      plain_key <= dec.plain_key;
    end
  end

  // The parser position is always exactly one of its one-hot codes.
  assert property (@(posedge clk) disable iff (rst) $onehot(parse_position))
    else $error("parser position is not one-hot");

  // Every command returns the parser to idle.
  assert property (@(posedge clk) disable iff (rst)
    advance && dec.has_result |=> parse_position == ST_IDLE)
    else $error("parser did not return to idle after a command");

  // Only plain key results carry a byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && command != CMD_PLAIN |-> plain_key == '0)
    else $error("plain_key nonzero on a sequence command");

  // The input side stalls only while a byte is held.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> held_valid)
    else $error("input stalled with an empty input register");

endmodule

### tb/key_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_check_pkg: expected-command tracking for the escape key decoder bench
// Follows the parser position byte by byte, works out the command that each
// accepted key byte should produce, and compares delivered results in order.
// ----------------------------------------------------------------------------
package key_check_pkg;

  import tekd_pkg::*;

  typedef struct {
    cmd_t                command;
    logic [KeyWidth-1:0] plain_key;
  } key_cmd_t;

  class key_cmd_tracker;
    state_t   parse_pos;
    key_cmd_t pending_cmds[$];
    int       errors;

    function new();
      parse_pos = ST_IDLE;
      errors    = 0;
    endfunction

    // Advance the parser by one accepted byte and queue any command it yields.
    function void note_key(logic [KeyWidth-1:0] b);
      int       code;
      state_t   nxt;
      key_cmd_t r;
      code = -1;
      nxt  = ST_IDLE;
      case (parse_pos)
        ST_IDLE: begin
          if (b == CH_ESC) nxt = ST_ESC;
          else code = CMD_PLAIN;
        end
        ST_ESC: begin
          if (b == CH_LBRACK) nxt = ST_CSI;
          else if (b == CH_O) nxt = ST_SS3;
          else if (b == CH_A) code = CMD_UP;
          else if (b == CH_B) code = CMD_DOWN;
          else if (b == CH_P) code = CMD_HELP;
          else if (b == CH_R) code = CMD_VIEW;
          else if (b == CH_S) code = CMD_DUMP;
        end
        ST_CSI: begin
          if (b == CH_A) code = CMD_UP;
          else if (b == CH_B) code = CMD_DOWN;
          else if (b == CH_5) nxt = ST_CSI5;
          else if (b == CH_6) nxt = ST_CSI6;
          else if (b == CH_H) code = CMD_HOME;
          else if (b == CH_F) code = CMD_END;
          else if (b == CH_1) nxt = ST_CSI1;
          else if (b == CH_2) nxt = ST_CSI2;
        end
        ST_SS3: begin
          if (b == CH_P) code = CMD_HELP;
          else if (b == CH_R) code = CMD_VIEW;
          else if (b == CH_S) code = CMD_DUMP;
          else if (b == CH_T) code = CMD_COPY;
          else if (b == CH_W) code = CMD_DELETE;
          else if (b == CH_Y) code = CMD_EXIT;
        end
        ST_CSI5: begin
          if (b == CH_TILDE) code = CMD_PGUP;
        end
        ST_CSI6: begin
          if (b == CH_TILDE) code = CMD_PGDN;
        end
        ST_CSI1: begin
          if (b == CH_5 || b == CH_6) nxt = ST_CSI15;
          else if (b == CH_9) nxt = ST_CSI19;
          else if (b == CH_7 || b == CH_8) nxt = ST_SKIP;
        end
        ST_CSI15: begin
          if (b == CH_TILDE) code = CMD_COPY;
        end
        ST_CSI19: begin
          if (b == CH_TILDE) code = CMD_DELETE;
        end
        ST_CSI2: begin
          if (b == CH_TILDE) code = CMD_SELECT;
          else if (b == CH_1) nxt = ST_CSI21;
          else if (b >= CH_0 && b <= CH_9) nxt = ST_SKIP;
        end
        ST_CSI21: begin
          if (b == CH_TILDE) code = CMD_EXIT;
          else nxt = ST_SKIP;
        end
        default: begin
        end
      endcase
      parse_pos = nxt;
      if (code >= 0) begin
        r.command   = cmd_t'(code);
        r.plain_key = (r.command == CMD_PLAIN) ? b : '0;
        pending_cmds.push_back(r);
      end
    endfunction

    // Compare one delivered result against the oldest outstanding command.
    function void check_result(logic [CmdWidth-1:0] cmd, logic [KeyWidth-1:0] key);
      key_cmd_t e;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual command=%0d plain_key=%02h",
                 $time, cmd, key);
        errors++;
        return;
      end
      e = pending_cmds.pop_front();
      if (cmd !== e.command) begin
        $display("%0t: command mismatch: expected %0d, actual %0d", $time, e.command, cmd);
        errors++;
      end
      if (key !== e.plain_key) begin
        $display("%0t: plain_key mismatch: expected %02h, actual %02h",
                 $time, e.plain_key, key);
        errors++;
      end
    endfunction

    function void flag_leftovers();
      foreach (pending_cmds[i]) begin
        $display("%0t: missing result: expected command=%0d plain_key=%02h, actual none",
                 $time, pending_cmds[i].command, pending_cmds[i].plain_key);
        errors++;
      end
    endfunction
  endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the terminal escape key decoder
// Feeds key bytes through the valid/stall input channel, first a few directed
// sequences and then random traffic built mostly from complete escape
// sequences, and checks every command beat against a byte-level parser model.
// ----------------------------------------------------------------------------
module tb_top;

  import tekd_pkg::*;
  import key_check_pkg::*;

  typedef logic [KeyWidth-1:0] key_seq_t[$];

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [KeyWidth-1:0] key_byte;
  logic                out_valid;
  logic                out_stall;
  logic [CmdWidth-1:0] command;
  logic [KeyWidth-1:0] plain_key;

  // When set, neither side inserts gaps, so the decoder runs back to back.
  bit          no_gaps;
  int unsigned bytes_sent;

  key_cmd_tracker tracker;

  terminal_escape_key_decoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key_byte  (key_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .command   (command),
    .plain_key (plain_key)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the decoder hangs. A correct run needs well under a
  // tenth of this time even with heavy stalling on both channels.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // The result side stalls in roughly a third of the cycles. The stall level
  // changes only on the falling edge, so it is stable at every rising edge.
  always @(negedge clk) begin
    out_stall = no_gaps ? 1'b0 : ($urandom_range(0, 99) < 33);
  end

  // Every result beat is checked against the oldest outstanding command. The
  // values read here are the ones held before the edge updates the registers.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_result(command, plain_key);
    end
  end

  // Present one key byte and hold it until the decoder accepts the beat.
  // Called on a falling edge and returns on the falling edge after acceptance
  // with valid still high, so back-to-back bytes never drop valid.
  task automatic send_key(input logic [KeyWidth-1:0] b);
    while (!no_gaps && $urandom_range(0, 99) < 33) begin
      in_valid = 1'b0;
      key_byte = 8'($urandom_range(0, 255));
      @(negedge clk);
    end
    in_valid = 1'b1;
    key_byte = b;
    do @(posedge clk); while (in_stall);
    tracker.note_key(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Filler byte for the tail of broken sequences: mostly uniform, sometimes a
  // byte on the edge of a decision (tilde, ESC, just outside the digit range).
  function automatic logic [KeyWidth-1:0] edge_byte();
    case ($urandom_range(0, 11))
      0:       return CH_TILDE;
      1:       return CH_ESC;
      2:       return CH_0 - 8'd1;
      3:       return CH_9 + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One random chunk of traffic. Most chunks are complete key sequences so
  // the deeper parser states are reached often; the rest are lone bytes and
  // sequences that break off or run into the skip rules.
  function automatic key_seq_t pick_sequence();
    key_seq_t            s;
    int                  roll;
    logic [KeyWidth-1:0] x;
    logic [KeyWidth-1:0] y;
    logic [KeyWidth-1:0] digit;
    roll  = $urandom_range(0, 99);
    x     = edge_byte();
    y     = edge_byte();
    digit = CH_0 + 8'($urandom_range(0, 9));
    if (roll < 15) begin
      s = '{8'($urandom_range(0, 255))};
    end else if (roll < 75) begin
      case ($urandom_range(0, 21))
        0:       s = '{CH_ESC, CH_LBRACK, CH_A};
        1:       s = '{CH_ESC, CH_LBRACK, CH_B};
        2:       s = '{CH_ESC, CH_LBRACK, CH_5, CH_TILDE};
        3:       s = '{CH_ESC, CH_LBRACK, CH_6, CH_TILDE};
        4:       s = '{CH_ESC, CH_LBRACK, CH_H};
        5:       s = '{CH_ESC, CH_LBRACK, CH_F};
        6:       s = '{CH_ESC, CH_LBRACK, CH_1, CH_5, CH_TILDE};
        7:       s = '{CH_ESC, CH_LBRACK, CH_1, CH_6, CH_TILDE};
        8:       s = '{CH_ESC, CH_LBRACK, CH_1, CH_9, CH_TILDE};
        9:       s = '{CH_ESC, CH_LBRACK, CH_2, CH_TILDE};
        10:      s = '{CH_ESC, CH_LBRACK, CH_2, CH_1, CH_TILDE};
        11:      s = '{CH_ESC, CH_O, CH_P};
        12:      s = '{CH_ESC, CH_O, CH_R};
        13:      s = '{CH_ESC, CH_O, CH_S};
        14:      s = '{CH_ESC, CH_O, CH_T};
        15:      s = '{CH_ESC, CH_O, CH_W};
        16:      s = '{CH_ESC, CH_O, CH_Y};
        17:      s = '{CH_ESC, CH_A};
        18:      s = '{CH_ESC, CH_B};
        19:      s = '{CH_ESC, CH_P};
        20:      s = '{CH_ESC, CH_R};
        default: s = '{CH_ESC, CH_S};
      endcase
    end else begin
      case ($urandom_range(0, 8))
        0:       s = '{CH_ESC, x};
        1:       s = '{CH_ESC, CH_LBRACK, x};
        2:       s = '{CH_ESC, CH_O, x};
        3:       s = '{CH_ESC, CH_LBRACK, ($urandom_range(0, 1) ? CH_5 : CH_6), x};
        4:       s = '{CH_ESC, CH_LBRACK, CH_1, x};
        5: begin
          case ($urandom_range(0, 2))
            0:       s = '{CH_ESC, CH_LBRACK, CH_1, CH_5, x};
            1:       s = '{CH_ESC, CH_LBRACK, CH_1, CH_6, x};
            default: s = '{CH_ESC, CH_LBRACK, CH_1, CH_9, x};
          endcase
        end
        // ESC [ 17 and ESC [ 18 swallow one trailing byte.
        6:       s = '{CH_ESC, CH_LBRACK, CH_1, ($urandom_range(0, 1) ? CH_7 : CH_8), x, y};
        // ESC [ 2 with a digit; a 1 here lands on the ESC [ 21 path.
        7:       s = '{CH_ESC, CH_LBRACK, CH_2, digit, x, y};
        default: s = '{CH_ESC, CH_LBRACK, CH_2, CH_1, x, y};
      endcase
    end
    return s;
  endfunction

  initial begin
    key_seq_t    directed;
    key_seq_t    chunk;
    int unsigned waited;

    tracker    = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    key_byte   = '0;
    no_gaps    = 1'b0;
    bytes_sent = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed bytes: the lowest and highest plain keys, a VT52 key, a second
    // ESC right after ESC (dropped), a skipped tilde after ESC [ 17, the skip
    // after ESC [ 21 with a non-tilde byte, a missing tilde after ESC [ 6,
    // and finally the exit key to show the parser is back in idle.
    directed = '{8'h00, 8'hFF,
                 CH_ESC, CH_A,
                 CH_ESC, CH_ESC,
                 CH_ESC, CH_LBRACK, CH_1, CH_7, CH_TILDE,
                 CH_ESC, CH_LBRACK, CH_2, CH_1, 8'h51, CH_TILDE,
                 CH_ESC, CH_LBRACK, CH_6, 8'h78,
                 CH_ESC, CH_LBRACK, CH_2, CH_1, CH_TILDE};
    foreach (directed[i]) send_key(directed[i]);

    // Random traffic. One stretch in the middle runs without any gaps on
    // either channel so that full-rate operation is exercised.
    while (bytes_sent < 1000) begin
      no_gaps = (bytes_sent >= 400 && bytes_sent < 550);
      chunk   = pick_sequence();
      foreach (chunk[i]) send_key(chunk[i]);
    end
    no_gaps  = 1'b0;
    in_valid = 1'b0;

    // Drain: wait for all outstanding commands, then a few more cycles so a
    // stray extra beat from the two-stage pipeline would still be caught.
    waited = 0;
    while (tracker.pending_cmds.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    tracker.flag_leftovers();

    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### terminal_escape_key_decoder_unit.f
src/tekd_pkg.sv
src/tekd_in_reg.sv
src/tekd_decode.sv
src/terminal_escape_key_decoder_unit.sv
tb/key_check_pkg.sv
tb/tb_top.sv
